### rtl/core/white_pink_noise_generator_macros.svh
// Assertion macros, sampled on clk, disabled during rst.
`ifndef WHITE_PINK_NOISE_GENERATOR_MACROS_SVH
`define WHITE_PINK_NOISE_GENERATOR_MACROS_SVH

// Same-cycle implication.
`define WPN_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define WPN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/wpn_pkg.sv
package wpn_pkg;

  localparam int NZ_POLES = 6;
  localparam int POLE_BITS = $clog2(NZ_POLES);
  localparam int LCG_MUL_BITS = 21;
  localparam logic [31:0] NZ_MUL = 32'd1664525;
  localparam logic [31:0] NZ_INC = 32'd1013904223;
  localparam logic [31:0] SEED_RESET = 32'd1;

  localparam logic [1:0] MODE_SILENCE = 2'd0;
  localparam logic [1:0] MODE_WHITE   = 2'd1;
  localparam logic [1:0] MODE_PINK    = 2'd2;

  localparam logic [1:0] REG_NOISE_MODE = 2'd0;
  localparam logic [1:0] REG_SEED       = 2'd1;

  // coefficients in millionths
  localparam logic [19:0] POLE_MICRO [NZ_POLES] =
    '{20'd997000, 20'd985000, 20'd950000, 20'd850000, 20'd620000, 20'd250000};
  localparam logic [19:0] GAIN_MICRO [NZ_POLES] =
    '{20'd29591, 20'd32534, 20'd48056, 20'd90579, 20'd108990, 20'd255784};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LCG_MUL,
    ST_LCG_ADD,
    ST_BW,
    ST_AA,
    ST_UPD,
    ST_FIN,
    ST_SAT,
    ST_DONE
  } wpn_state_t;

  typedef struct packed {
    wpn_state_t             state;
    logic [POLE_BITS-1:0]   pole;
    logic                   out_load;
  } wpn_ctl_t;

  // round(micro * 2^cb / 1e6), halves up; elaboration only
  function automatic logic [63:0] to_coef(input logic [19:0] micro, input int cb);
    return ((64'(micro) << cb) + 64'd500000) / 64'd1000000;
  endfunction

endpackage

### rtl/core/white_pink_noise_generator.sv
// New input waits until idle; a tick of 0 does nothing. Silent tick goes straight to done;
// white runs the LCG multiply and add; pink adds the pole loop, final sum and saturation.
// Pink cost is set by one shared multiplier: two products and one update per pole, six poles.
// Reset (rst, synchronous): mode silence, generator state 1, pole accumulators zero.
// A seed write reloads the generator state at once.
module white_pink_noise_generator import wpn_pkg::*; #(
  parameter int COEF_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [31:0]        wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               tick,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [27:0] sample
);

`include "white_pink_noise_generator_macros.svh"

  localparam int AW = (COEF_BITS > LCG_MUL_BITS) ? COEF_BITS : LCG_MUL_BITS;
  localparam int PW = AW + 33;
  localparam int MW = PW + 1;
  localparam logic [MW-1:0] HALF = {{(MW-1){1'b0}}, 1'b1} << (COEF_BITS - 1);

  localparam logic [AW-1:0] A_COEF [NZ_POLES] = '{
    AW'(to_coef(POLE_MICRO[0], COEF_BITS)), AW'(to_coef(POLE_MICRO[1], COEF_BITS)),
    AW'(to_coef(POLE_MICRO[2], COEF_BITS)), AW'(to_coef(POLE_MICRO[3], COEF_BITS)),
    AW'(to_coef(POLE_MICRO[4], COEF_BITS)), AW'(to_coef(POLE_MICRO[5], COEF_BITS))};
  localparam logic [AW-1:0] B_COEF [NZ_POLES] = '{
    AW'(to_coef(GAIN_MICRO[0], COEF_BITS)), AW'(to_coef(GAIN_MICRO[1], COEF_BITS)),
    AW'(to_coef(GAIN_MICRO[2], COEF_BITS)), AW'(to_coef(GAIN_MICRO[3], COEF_BITS)),
    AW'(to_coef(GAIN_MICRO[4], COEF_BITS)), AW'(to_coef(GAIN_MICRO[5], COEF_BITS))};

  wpn_ctl_t ctl;

  logic [1:0]         noise_mode;
  logic [31:0]        lcg_state;
  logic signed [31:0] acc [NZ_POLES];

  logic signed [22:0] w;
  logic signed [MW-1:0] mac;
  logic signed [34:0] sum;
  logic signed [31:0] last;
  logic signed [27:0] res;

  logic [AW-1:0]        mul_a;
  logic signed [32:0]   mul_b;
  logic signed [PW-1:0] prod;

  logic [31:0]          lcg_next;
  logic signed [22:0]   white_next;
  logic signed [MW-1:0] mac_sum;
  logic signed [MW-1:0] shifted;
  logic [MW-32:0]       sh_hi;
  logic signed [31:0]   upd_val;
  logic signed [34:0]   sum_ext;
  logic [7:0]           sum_hi;
  logic signed [27:0]   sum_sat;

  wpn_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .tick       (tick),
    .noise_mode (noise_mode),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ctl        (ctl)
  );

  wpn_mul #(.AW(AW)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign in_stall = (ctl.state != ST_IDLE);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctl.state)
      ST_LCG_MUL: begin
        mul_a = AW'(NZ_MUL);
        mul_b = $signed({1'b0, lcg_state});
      end
      ST_BW: begin
        mul_a = B_COEF[ctl.pole];
        mul_b = $signed({{10{w[22]}}, w});
      end
      ST_AA: begin
        mul_a = A_COEF[ctl.pole];
        mul_b = $signed({acc[ctl.pole][31], acc[ctl.pole]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign lcg_next   = prod[31:0] + NZ_INC;
  assign white_next = $signed({~lcg_next[22], lcg_next[21:0]});

  assign mac_sum = mac + $signed({prod[PW-1], prod});
  assign shifted = mac_sum >>> COEF_BITS;
  assign sh_hi   = shifted[MW-1:31];
  assign upd_val = (&sh_hi || ~|sh_hi) ? shifted[31:0] :
                   (shifted[MW-1] ? 32'sh80000000 : 32'sh7fffffff);

  assign sum_ext = sum + $signed({{3{last[31]}}, last});
  assign sum_hi  = sum[34:27];
  assign sum_sat = (&sum_hi || ~|sum_hi) ? sum[27:0] :
                   (sum[34] ? 28'sh8000000 : 28'sh7ffffff);

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_mode <= MODE_SILENCE;
      lcg_state  <= SEED_RESET;
      out_valid  <= 1'b0;
      for (int i = 0; i < NZ_POLES; i++) begin
        acc[i] <= '0;
      end
    end else begin
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (ctl.state == ST_LCG_ADD) begin
        lcg_state <= lcg_next;
      end
      if (ctl.state == ST_UPD) begin
        acc[ctl.pole] <= upd_val;
      end
      if (wr_en) begin
        if (wr_index == REG_NOISE_MODE) begin
          noise_mode <= wr_data[1:0];
        end else if (wr_index == REG_SEED) begin
          lcg_state <= wr_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      sample <= res;
    end
    unique case (ctl.state)
      ST_IDLE: res <= '0;
      ST_LCG_ADD: begin
        w    <= white_next;
        res  <= 28'(white_next);
        sum  <= '0;
        last <= '0;
      end
      ST_BW:  sum  <= sum_ext;
      ST_AA:  mac  <= $signed({prod[PW-1], prod}) + $signed(HALF);
      ST_UPD: last <= upd_val;
      ST_FIN: sum  <= sum_ext;
      ST_SAT: res  <= sum_sat;
      default: ;
    endcase
  end

  `WPN_ASSERT_IMPL(a_out_from_done, $rose(out_valid), $past(ctl.state) == ST_DONE, "out_valid rose outside done")
  `WPN_ASSERT_NEXT(a_silence_holds_lcg, in_valid && !in_stall && tick && noise_mode != MODE_WHITE && noise_mode != MODE_PINK && !(wr_en && wr_index == REG_SEED), $stable(lcg_state) && ctl.state == ST_DONE, "silent tick changed generator")
  `WPN_ASSERT_IMPL(a_pole_range, ctl.state == ST_BW || ctl.state == ST_AA || ctl.state == ST_UPD, ctl.pole <= POLE_BITS'(NZ_POLES - 1), "pole index out of range")

endmodule

### rtl/core/wpn_mul.sv
module wpn_mul import wpn_pkg::*; #(
  parameter int AW = 24
) (
  input  logic                 clk,
  input  logic [AW-1:0]        a,
  input  logic signed [32:0]   b,
  output logic signed [AW+32:0] p
);

  logic signed [AW+33:0] full;

  assign full = $signed({1'b0, a}) * b;

  always_ff @(posedge clk) begin
    p <= $signed(full[AW+32:0]);
  end

endmodule

### rtl/core/wpn_ctrl.sv
module wpn_ctrl import wpn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       tick,
  input  logic [1:0] noise_mode,
  input  logic       out_valid,
  input  logic       out_stall,
  output wpn_ctl_t   ctl
);

  wpn_state_t           state, state_next;
  logic [POLE_BITS-1:0] pole, pole_next;
  logic                 out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pole  <= '0;
    end else begin
      state <= state_next;
      pole  <= pole_next;
    end
  end

  always_comb begin
    state_next = state;
    pole_next  = pole;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && tick) begin
          if (noise_mode == MODE_WHITE || noise_mode == MODE_PINK) begin
            state_next = ST_LCG_MUL;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_LCG_MUL: state_next = ST_LCG_ADD;
      ST_LCG_ADD: begin
        pole_next = '0;
        if (noise_mode == MODE_WHITE) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_BW;
        end
      end
      ST_BW: state_next = ST_AA;
      ST_AA: state_next = ST_UPD;
      ST_UPD: begin
        if (pole == POLE_BITS'(NZ_POLES - 1)) begin
          state_next = ST_FIN;
        end else begin
          pole_next  = pole + 1'b1;
          state_next = ST_BW;
        end
      end
      ST_FIN: state_next = ST_SAT;
      ST_SAT: state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign ctl.state    = state;
  assign ctl.pole     = pole;
  assign ctl.out_load = out_load;

endmodule
